// ===== src/ots_pkg.sv =====
package ots_pkg;

  // input item: start or frame length measurement
  typedef struct packed {
    logic        action;
    logic [15:0] frame_length;
  } ots_in_t;

  // result item: trial trim or final best trim
  typedef struct packed {
    logic [7:0] trim_value;
    logic       done_res;
  } ots_out_t;

  // action codes
  localparam logic ActStart   = 1'b0;
  localparam logic ActMeasure = 1'b1;

  // reset and search constants
  localparam logic [15:0] TargetReset   = 16'd2356;
  localparam logic [15:0] InitDeviation = 16'd9999;
  localparam logic [6:0]  FirstStep     = 7'd64;

endpackage

// ===== src/oscillator_trim_search_unit.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------------
// in       | input     | in_valid_i/in_stall_o   | ots_in_t (action, length)
// out      | output    | out_valid_o/out_stall_i | ots_out_t (trim, done)
// cfg      | input     | cfg_valid_i/cfg_ready_o | target frame length
//
// one transaction per cycle while in_stall_o is low; each result is registered in the output
// register, or in the skid entry behind it, by the single state update stage
// a two-entry output buffer (result register plus skid) lets the next input
// be taken while a result waits; in_stall_o rises only when both are full
// reset clears the search state to idle and the target to its default
// cfg_ready_o is always high; the user must write only while the search is idle (not enforced)
module oscillator_trim_search_unit
  import ots_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ots_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ots_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] target_q;
  logic        busy_q,   busy_d;
  logic        region_q, region_d;
  logic [6:0]  step_q,   step_d;
  logic [7:0]  trial_q,  trial_d;
  logic [7:0]  best_q,   best_d;
  logic [15:0] best_dev_q, best_dev_d;

  logic        out_valid_q, skid_valid_q;
  ots_out_t    out_data_q, skid_data_q;

  logic        in_acc;
  logic        out_take;
  logic        res_valid;
  ots_out_t    res;
  logic        len_lt;
  logic [15:0] dev;
  logic        improve;
  logic        step_last;
  logic [6:0]  step_half;
  logic [7:0]  trim_step;
  logic [7:0]  first_low;
  logic [7:0]  first_high;

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // target length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // deviation and step arithmetic
  assign len_lt    = in_data_i.frame_length < target_q;
  assign dev       = len_lt ? (target_q - in_data_i.frame_length)
                            : (in_data_i.frame_length - target_q);
  assign improve   = dev < best_dev_q;
  assign step_last = (step_q[6:1] == 6'd0);
  assign step_half = step_q >> 1;
  assign trim_step = {1'b0, step_half};
  // first trial of a region: the start step compares a zero length
  assign first_low  = (target_q != 16'd0) ? (8'd0 + {1'b0, FirstStep})
                                          : (8'd0 - {1'b0, FirstStep});
  assign first_high = (target_q != 16'd0) ? (8'd128 + {1'b0, FirstStep})
                                          : (8'd128 - {1'b0, FirstStep});

  // search update for the accepted transaction
  always_comb begin
    busy_d     = busy_q;
    region_d   = region_q;
    step_d     = step_q;
    trial_d    = trial_q;
    best_d     = best_q;
    best_dev_d = best_dev_q;
    res_valid  = 1'b0;
    res        = '0;
    if (in_acc) begin
      unique case (in_data_i.action)
        ActStart: begin
          busy_d           = 1'b1;
          region_d         = 1'b0;
          step_d           = FirstStep;
          best_d           = 8'd0;
          best_dev_d       = InitDeviation;
          trial_d          = first_low;
          res_valid        = 1'b1;
          res.trim_value   = first_low;
          res.done_res     = 1'b0;
        end
        ActMeasure: begin
          if (busy_q) begin
            if (improve) begin
              best_d     = trial_q;
              best_dev_d = dev;
            end
            res_valid = 1'b1;
            if (step_last && !region_q) begin
              // move to the upper region
              region_d       = 1'b1;
              step_d         = FirstStep;
              trial_d        = first_high;
              res.trim_value = first_high;
              res.done_res   = 1'b0;
            end else if (step_last) begin
              // search finished, emit best trim
              busy_d         = 1'b0;
              res.trim_value = improve ? trial_q : best_q;
              res.done_res   = 1'b1;
            end else begin
              step_d         = step_half;
              trial_d        = len_lt ? (trial_q + trim_step) : (trial_q - trim_step);
              res.trim_value = trial_d;
              res.done_res   = 1'b0;
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  // search state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      region_q   <= 1'b0;
      step_q     <= FirstStep;
      trial_q    <= 8'd0;
      best_q     <= 8'd0;
      best_dev_q <= InitDeviation;
    end else begin
      busy_q     <= busy_d;
      region_q   <= region_d;
      step_q     <= step_d;
      trial_q    <= trial_d;
      best_q     <= best_d;
      best_dev_q <= best_dev_d;
    end
  end

  // output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_data_q <= res;
      end else begin
        out_data_q <= res;
      end
    end
  end

  // skid entry only holds data behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  // step size is always a single power of two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(step_q))
    else $error("step size not a power of two");

  // search ends only with a done result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(res_valid && res.done_res))
    else $error("search ended without done result");

  // a measurement while idle gives no result and keeps the state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.action == ActMeasure) && !busy_q)
      |=> !$past(res_valid) && $stable(trial_q) && $stable(best_dev_q))
    else $error("idle measurement changed the search");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import ots_pkg::*;

  localparam int          HalfPeriod  = 4;
  localparam int          ResetCycles = 4;
  localparam int          CycleLimit  = 400000;
  localparam int          SettleGap   = 4;
  localparam int          HoldCycles  = 300;
  localparam int          HoldAfter   = 400;
  localparam int          TailCycles  = 16;
  localparam int          PrintCap    = 60;
  localparam logic [7:0]  UpperBase   = 8'd128;
  localparam int          SearchLen   = 14;

  // one entry of the sender queue: an input item, a register write or a pause
  typedef enum logic [1:0] {FeedItem, FeedCfg, FeedPause} feed_kind_e;
  typedef struct {
    feed_kind_e  kind;
    ots_in_t     data;
    logic [15:0] cfg_val;
  } feed_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  ots_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  ots_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i  = '0;

  feed_t       feed_q[$];
  ots_out_t    trims_due[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          accepted_items = 0;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        hold_off = 1'b0;
  logic [15:0] gen_target;

  // mirror of the search state
  logic [15:0] tgt_len = TargetReset;
  logic        s_busy = 1'b0;
  logic        s_region = 1'b0;
  logic [6:0]  s_step = FirstStep;
  logic [7:0]  s_trial = '0;
  logic [7:0]  s_best = '0;
  logic [15:0] s_best_dev = InitDeviation;

  oscillator_trim_search_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  task automatic log_mismatch(input string msg);
    if (mismatches < PrintCap) $display("mismatch @%0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  // first trial of a region: a zero measurement compared against the target
  function automatic logic [7:0] opening_trial(input logic [7:0] base);
    if (tgt_len > 16'd0) return base + 8'(FirstStep);
    return base - 8'(FirstStep);
  endfunction

  task automatic push_trim(input logic [7:0] trim, input logic done);
    ots_out_t r;
    r.trim_value = trim;
    r.done_res   = done;
    trims_due.push_back(r);
  endtask

  // advance the search mirror by one accepted transaction
  task automatic search_step(input ots_in_t it);
    logic [15:0] dev;
    if (it.action == ActStart) begin
      s_busy     = 1'b1;
      s_region   = 1'b0;
      s_step     = FirstStep;
      s_best     = '0;
      s_best_dev = InitDeviation;
      s_trial    = opening_trial(8'd0);
      push_trim(s_trial, 1'b0);
    end else if (s_busy) begin
      dev = (it.frame_length >= tgt_len) ? it.frame_length - tgt_len
                                         : tgt_len - it.frame_length;
      if (dev < s_best_dev) begin
        s_best     = s_trial;
        s_best_dev = dev;
      end
      if (s_step <= 7'd1) begin
        if (s_region == 1'b0) begin
          s_region = 1'b1;
          s_step   = FirstStep;
          s_trial  = opening_trial(UpperBase);
          push_trim(s_trial, 1'b0);
        end else begin
          s_busy = 1'b0;
          push_trim(s_best, 1'b1);
        end
      end else begin
        s_step = s_step >> 1;
        if (it.frame_length < tgt_len) s_trial = s_trial + 8'(s_step);
        else s_trial = s_trial - 8'(s_step);
        push_trim(s_trial, 1'b0);
      end
    end
  endtask

  // sampling at the rising edge: results, then inputs and register writes
  always @(posedge clk_i) begin : sample
    ots_out_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("oscillator_trim_search_unit verification failed");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (trims_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result trim %0d done %0b",
                                 out_data_o.trim_value, out_data_o.done_res));
        end else begin
          want = trims_due.pop_front();
          if (out_data_o.trim_value !== want.trim_value)
            log_mismatch($sformatf("trim_value %0d, expected %0d",
                                   out_data_o.trim_value, want.trim_value));
          if (out_data_o.done_res !== want.done_res)
            log_mismatch($sformatf("done_res %0b, expected %0b",
                                   out_data_o.done_res, want.done_res));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        search_step(in_data_i);
        accepted_items <= accepted_items + 1;
      end
      if (cfg_valid_i && cfg_ready_o) tgt_len = cfg_data_i;
    end
    in_taken  <= rst_ni && in_valid_i && !in_stall_o;
    cfg_taken <= rst_ni && cfg_valid_i && cfg_ready_o;
  end

  // sender: bursts of items with gaps, pauses for writes and drains
  int burst_left = 1;
  int gap_left = 0;
  int quiet_cnt = 0;

  always @(negedge clk_i) begin : driver
    logic        nv;
    ots_in_t     nd;
    logic        ncv;
    logic [15:0] ncd;
    feed_t       f;
    nv  = in_valid_i;
    nd  = in_data_i;
    ncv = cfg_valid_i;
    ncd = cfg_data_i;
    if (trims_due.size() == 0) quiet_cnt++;
    else quiet_cnt = 0;
    if (rst_ni) begin
      if (in_valid_i && in_taken) nv = 1'b0;
      if (cfg_valid_i && cfg_taken) ncv = 1'b0;
      if (!nv && !ncv && feed_q.size() > 0) begin
        if (feed_q[0].kind != FeedItem) begin
          // wait for every result and for the result queue to stay empty past the settling gap
          if (quiet_cnt > SettleGap && !in_valid_i) begin
            f = feed_q.pop_front();
            if (f.kind == FeedCfg) begin
              ncv = 1'b1;
              ncd = f.cfg_val;
            end
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          f  = feed_q.pop_front();
          nv = 1'b1;
          nd = f.data;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid_i  <= nv;
    in_data_i   <= nd;
    cfg_valid_i <= ncv;
    cfg_data_i  <= ncd;
  end

  // receiver: stall pattern in changing modes, plus the long hold-off
  int stall_run = 0;
  int stall_mode = 0;

  always @(negedge clk_i) begin : receiver
    logic st;
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(16, 96);
    end
    stall_run--;
    case (stall_mode)
      0: begin
        st = 1'b0;
      end
      1: begin
        st = ($urandom_range(0, 3) == 0);
      end
      2: begin
        st = ($urandom_range(0, 3) != 0);
      end
      default: begin
        st = stall_run[2];
      end
    endcase
    out_stall_i <= st || hold_off;
  end

  initial begin : long_hold
    wait (accepted_items >= HoldAfter);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // stimulus helpers
  task automatic add_item(input logic act, input logic [15:0] len);
    feed_t f;
    f.kind              = FeedItem;
    f.data.action       = act;
    f.data.frame_length = len;
    f.cfg_val           = '0;
    feed_q.push_back(f);
  endtask

  task automatic add_cfg(input logic [15:0] val);
    feed_t f;
    f.kind    = FeedCfg;
    f.data    = '0;
    f.cfg_val = val;
    feed_q.push_back(f);
    gen_target = val;
  endtask

  task automatic add_pause();
    feed_t f;
    f.kind    = FeedPause;
    f.data    = '0;
    f.cfg_val = '0;
    feed_q.push_back(f);
  endtask

  // measurement lengths mostly near the target, with extremes and noise
  function automatic logic [15:0] pick_length();
    int span;
    int d;
    case ($urandom_range(0, 9))
      0: begin
        return 16'd0;
      end
      1: begin
        return 16'hFFFF;
      end
      2: begin
        return gen_target;
      end
      3, 4: begin
        return 16'($urandom_range(0, 65535));
      end
      default: begin
        span = 1 << $urandom_range(0, 12);
        d    = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 0) return gen_target + 16'(d);
        return gen_target - 16'(d);
      end
    endcase
  endfunction

  task automatic add_search(input int measures);
    add_item(ActStart, 16'($urandom_range(0, 65535)));
    repeat (measures) add_item(ActMeasure, pick_length());
  endtask

  // one phase of random sequences, closed by a full search so the block is idle
  task automatic add_phase(input int items, input bit mid_pause);
    int n;
    int k;
    n = 0;
    while (n < items) begin
      k = $urandom_range(0, 19);
      if (k < 14) begin
        add_search(SearchLen);
        n += SearchLen + 1;
      end else if (k < 17) begin
        k = $urandom_range(1, SearchLen - 1);
        add_search(k);
        n += k + 1;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) add_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        n += k;
      end
      if (mid_pause && n >= items / 2) begin
        add_pause();
        mid_pause = 0;
      end
    end
    add_search(SearchLen);
  endtask

  initial begin : stimulus
    logic [15:0] lens[SearchLen];
    int guard;
    gen_target = TargetReset;

    // directed: measurement while idle, restart while busy, length extremes
    add_item(ActMeasure, 16'hFFFF);
    add_item(ActStart, 16'h0000);
    add_item(ActMeasure, 16'd0);
    add_item(ActMeasure, 16'hFFFF);
    add_item(ActMeasure, TargetReset);
    add_item(ActStart, 16'hFFFF);
    lens = '{16'd2356, 16'd2355, 16'd2357, 16'd0, 16'hFFFF, 16'd2300, 16'd2400,
             16'd2356, 16'd1, 16'hFFFE, 16'd2350, 16'd2360, 16'd2356, 16'd2000};
    foreach (lens[i]) add_item(ActMeasure, lens[i]);
    add_item(ActMeasure, 16'h5555);

    // target zero: first trial wraps, then a search with no improvement
    add_cfg(16'd0);
    add_item(ActStart, 16'hAAAA);
    repeat (SearchLen) add_item(ActMeasure, 16'($urandom_range(10000, 65535)));
    add_phase(80, 1'b0);

    add_cfg(16'hFFFF);
    add_phase(100, 1'b1);
    add_cfg(TargetReset);
    add_phase(100, 1'b0);
    add_cfg(16'($urandom_range(0, 65535)));
    add_phase(100, 1'b0);
    add_cfg(16'd1);
    add_phase(95, 1'b0);
    add_cfg(16'hFFFE);
    add_phase(95, 1'b0);
    add_cfg(16'($urandom_range(0, 65535)));
    add_phase(95, 1'b0);

    // release reset and let the driver run dry
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (feed_q.size() == 0 && !in_valid_i && !cfg_valid_i);
    guard = 0;
    while (trims_due.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (trims_due.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", trims_due.size()));
    if (mismatches == 0) begin
      $display("oscillator_trim_search_unit verification clean");
    end else begin
      $display("oscillator_trim_search_unit verification failed");
    end
    $finish;
  end

endmodule
